// File: hw/rtl/rosy_field_vector_expand_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rosy field vector expansion block
// Both macros check on the rising edge of clk_i and are held off in reset.
// ----------------------------------------------------------------------------
`ifndef ROSY_FIELD_VECTOR_EXPAND_DEFINES_SVH
`define ROSY_FIELD_VECTOR_EXPAND_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define RFVE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define RFVE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rfve_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfve_pkg
// Widths, CORDIC constants and shared types for the field vector expansion.
// ----------------------------------------------------------------------------
package rfve_pkg;

  localparam int unsigned MAX_DEGREE_DEF  = 9;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned CORDIC_STEPS    = 24;

  localparam int unsigned R_W       = 24;
  localparam int unsigned B_W       = 16;
  localparam int unsigned OUT_W     = 24;
  localparam int unsigned DEG_REG_W = 4;
  localparam int unsigned COPY_W    = 4;
  localparam int unsigned ANG_W     = 32;
  localparam int unsigned LEN_W     = 24;

  // 1/K of the CORDIC gain in Q.30
  localparam logic signed [33:0] GAIN_INV = 34'sd652032874;

  // atan(2^-i) in units of a full turn = 2^32
  localparam logic [ANG_W-1:0] TURN_ATAN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // One classified face waiting in the queue
  typedef struct packed {
    logic [ANG_W-1:0]        phi;
    logic [LEN_W-1:0]        len;
    logic [2:0][B_W-1:0]     b1;
    logic [2:0][B_W-1:0]     b2;
  } face_t;

  // Per-copy side data carried down the back pipeline
  typedef struct packed {
    logic [2:0][B_W-1:0]     b1;
    logic [2:0][B_W-1:0]     b2;
    logic [LEN_W-1:0]        len;
    logic [COPY_W-1:0]       copy_index;
    logic                    last_copy;
  } copy_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hw/rtl/rfve_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfve_face_if / rfve_vec_if
// Valid/ready channels for input faces and output field vectors.
// ----------------------------------------------------------------------------
interface rfve_face_if import rfve_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [R_W-1:0] r_x;
  logic signed [R_W-1:0] r_y;
  logic signed [R_W-1:0] r_z;
  logic signed [B_W-1:0] b1_x;
  logic signed [B_W-1:0] b1_y;
  logic signed [B_W-1:0] b1_z;
  logic signed [B_W-1:0] b2_x;
  logic signed [B_W-1:0] b2_y;
  logic signed [B_W-1:0] b2_z;

  modport source (
    output valid, r_x, r_y, r_z, b1_x, b1_y, b1_z, b2_x, b2_y, b2_z,
    input  ready
  );
  modport sink (
    input  valid, r_x, r_y, r_z, b1_x, b1_y, b1_z, b2_x, b2_y, b2_z,
    output ready
  );
endinterface

interface rfve_vec_if import rfve_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_x;
  logic signed [OUT_W-1:0] out_y;
  logic signed [OUT_W-1:0] out_z;
  logic [COPY_W-1:0]       copy_index;
  logic                    last_copy;

  modport source (
    output valid, out_x, out_y, out_z, copy_index, last_copy,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, copy_index, last_copy,
    output ready
  );
endinterface

// File: hw/rtl/rfve_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfve_front
// Accepts faces, projects the vector on the basis, finds its in-plane angle
// with a pipelined CORDIC and its 3D length with a pipelined square root.
// ----------------------------------------------------------------------------
module rfve_front import rfve_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfve_face_if.sink   face_i,
  input  q_stat_t     q_stat_i,
  output logic        push_o,
  output face_t       entry_o
);

  localparam int unsigned NS   = CORDIC_STEPS;
  localparam int unsigned PR_W = R_W + B_W;      // r*b product
  localparam int unsigned SQ_W = 2 * R_W;        // sum of squares
  localparam int unsigned VW   = 54;             // vectoring datapath

  logic en;

  // Stall the whole pipe only when the finished face cannot enter the queue
  logic last_vld;
  assign en           = !(last_vld && q_stat_i.full);
  assign face_i.ready = en;

  // --------------------------------------------------------------------------
  // Stage 0: products
  // --------------------------------------------------------------------------
  logic signed [R_W-1:0]  rv [3];
  logic signed [B_W-1:0]  e1 [3];
  logic signed [B_W-1:0]  e2 [3];

  assign rv[0] = face_i.r_x;  assign rv[1] = face_i.r_y;  assign rv[2] = face_i.r_z;
  assign e1[0] = face_i.b1_x; assign e1[1] = face_i.b1_y; assign e1[2] = face_i.b1_z;
  assign e2[0] = face_i.b2_x; assign e2[1] = face_i.b2_y; assign e2[2] = face_i.b2_z;

  logic                   p_vld_q;
  logic signed [PR_W-1:0] pa_prod_q [3];
  logic signed [PR_W-1:0] pb_prod_q [3];
  logic [SQ_W-1:0]        sq_prod_q [3];
  logic [2:0][B_W-1:0]    p_b1_q;
  logic [2:0][B_W-1:0]    p_b2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en) begin
      p_vld_q <= face_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        pa_prod_q[c] <= rv[c] * e1[c];
        pb_prod_q[c] <= rv[c] * e2[c];
        sq_prod_q[c] <= SQ_W'(rv[c]) * SQ_W'(rv[c]);
        p_b1_q[c]    <= e1[c];
        p_b2_q[c]    <= e2[c];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 (index 0): sums, half-plane fold, zero detect, root init
  // Stages 2..NS+1 (index 1..NS): one vectoring and one root step each
  // --------------------------------------------------------------------------
  logic                  vld_q   [NS+1];
  logic signed [VW-1:0]  pa_q    [NS+1];
  logic signed [VW-1:0]  pb_q    [NS+1];
  logic [ANG_W-1:0]      acc_q   [NS+1];
  logic                  zero_q  [NS+1];
  logic [SQ_W-1:0]       rem_q   [NS+1];
  logic [SQ_W-1:0]       res_q   [NS+1];
  logic [2:0][B_W-1:0]   b1_q    [NS+1];
  logic [2:0][B_W-1:0]   b2_q    [NS+1];

  logic                  vld_d   [NS+1];
  logic signed [VW-1:0]  pa_d    [NS+1];
  logic signed [VW-1:0]  pb_d    [NS+1];
  logic [ANG_W-1:0]      acc_d   [NS+1];
  logic                  zero_d  [NS+1];
  logic [SQ_W-1:0]       rem_d   [NS+1];
  logic [SQ_W-1:0]       res_d   [NS+1];
  logic [2:0][B_W-1:0]   b1_d    [NS+1];
  logic [2:0][B_W-1:0]   b2_d    [NS+1];

  // Sum projections and squares, move the vector into the right half plane
  always_comb begin
    logic signed [VW-1:0] sa;
    logic signed [VW-1:0] sb;
    sa = VW'(pa_prod_q[0]) + VW'(pa_prod_q[1]) + VW'(pa_prod_q[2]);
    sb = VW'(pb_prod_q[0]) + VW'(pb_prod_q[1]) + VW'(pb_prod_q[2]);
    vld_d[0]  = p_vld_q;
    zero_d[0] = (sa == '0) && (sb == '0);
    if (sa < 0) begin
      pa_d[0]  = -sa;
      pb_d[0]  = -sb;
      acc_d[0] = 32'h8000_0000;
    end else begin
      pa_d[0]  = sa;
      pb_d[0]  = sb;
      acc_d[0] = '0;
    end
    rem_d[0] = sq_prod_q[0] + sq_prod_q[1] + sq_prod_q[2];
    res_d[0] = '0;
    b1_d[0]  = p_b1_q;
    b2_d[0]  = p_b2_q;
  end

  for (genvar s = 1; s <= NS; s++) begin : g_vec
    localparam int unsigned ST = s - 1;
    localparam logic [SQ_W-1:0] RBIT = SQ_W'(1) << (2 * (NS - 1 - ST));

    // Rotate toward the x axis and take one digit of the root
    always_comb begin
      logic signed [VW-1:0] da;
      logic signed [VW-1:0] db;
      logic [SQ_W-1:0]      trial;
      da = pa_q[s-1] >>> ST;
      db = pb_q[s-1] >>> ST;
      if (pb_q[s-1] > 0) begin
        pa_d[s]  = pa_q[s-1] + db;
        pb_d[s]  = pb_q[s-1] - da;
        acc_d[s] = acc_q[s-1] + TURN_ATAN[ST];
      end else begin
        pa_d[s]  = pa_q[s-1] - db;
        pb_d[s]  = pb_q[s-1] + da;
        acc_d[s] = acc_q[s-1] - TURN_ATAN[ST];
      end
      trial = res_q[s-1] + RBIT;
      if (rem_q[s-1] >= trial) begin
        rem_d[s] = rem_q[s-1] - trial;
        res_d[s] = (res_q[s-1] >> 1) + RBIT;
      end else begin
        rem_d[s] = rem_q[s-1];
        res_d[s] = res_q[s-1] >> 1;
      end
      vld_d[s]  = vld_q[s-1];
      zero_d[s] = zero_q[s-1];
      b1_d[s]   = b1_q[s-1];
      b2_d[s]   = b2_q[s-1];
    end
  end

  for (genvar s = 0; s <= NS; s++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_d[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        pa_q[s]   <= pa_d[s];
        pb_q[s]   <= pb_d[s];
        acc_q[s]  <= acc_d[s];
        zero_q[s] <= zero_d[s];
        rem_q[s]  <= rem_d[s];
        res_q[s]  <= res_d[s];
        b1_q[s]   <= b1_d[s];
        b2_q[s]   <= b2_d[s];
      end
    end
  end

  // Hand the finished face to the queue
  assign last_vld      = vld_q[NS];
  assign push_o        = vld_q[NS] && en;
  assign entry_o.phi   = zero_q[NS] ? '0 : acc_q[NS];
  assign entry_o.len   = res_q[NS][LEN_W-1:0];
  assign entry_o.b1    = b1_q[NS];
  assign entry_o.b2    = b2_q[NS];

endmodule

// File: hw/rtl/rfve_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfve_fifo
// Short queue of classified faces between the front and the back.
// ----------------------------------------------------------------------------
module rfve_fifo import rfve_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  face_t   data_i,
  input  logic    pop_i,
  output face_t   data_o,
  output q_stat_t stat_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  face_t             mem_q [DEPTH];
  logic [AW-1:0]     wptr_q, wptr_d;
  logic [AW-1:0]     rptr_q, rptr_d;
  logic [AW:0]       cnt_q, cnt_d;

  // Advance pointers with wrap at the depth
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (32'(wptr_q) == DEPTH - 1) ? '0 : wptr_q + AW'(1);
    end
    if (pop_i) begin
      rptr_d = (32'(rptr_q) == DEPTH - 1) ? '0 : rptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rptr_q];
  assign stat_o.full  = (32'(cnt_q) == DEPTH);
  assign stat_o.empty = (cnt_q == '0);

endmodule

// File: hw/rtl/rfve_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfve_back
// Walks each queued face's symmetric copies, one per unstalled cycle, via a
// pipelined CORDIC rotation, basis rebuild, length scaling and saturation.
// ----------------------------------------------------------------------------
module rfve_back import rfve_pkg::*; #(
  parameter  int unsigned MAX_DEGREE = MAX_DEGREE_DEF,
  localparam int unsigned DEG_W      = $clog2(MAX_DEGREE + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DEG_W-1:0] deg_i,
  input  q_stat_t          q_stat_i,
  input  face_t            entry_i,
  output logic             pop_o,
  rfve_vec_if.source       vec_o
);

  localparam int unsigned NS   = CORDIC_STEPS;
  localparam int unsigned CW   = 34;               // rotation datapath
  localparam int unsigned PW   = CW + B_W;         // c*b product
  localparam int unsigned TW   = 32;               // rebuilt unit component
  localparam int unsigned MW   = LEN_W + 1 + TW;   // L*t product
  localparam logic signed [CW-1:0] QTR  = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] HALF = CW'(64'sd2147483648);
  localparam logic signed [OUT_W:0] OMAX = (OUT_W+1)'(2**(OUT_W-1) - 1);

  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || vec_o.ready;

  // --------------------------------------------------------------------------
  // Copy spacing 2^32/D as quotient and remainder for every degree
  // --------------------------------------------------------------------------
  logic [ANG_W-1:0] step_q_tab [MAX_DEGREE+1];
  logic [DEG_W-1:0] step_r_tab [MAX_DEGREE+1];

  for (genvar g = 0; g <= MAX_DEGREE; g++) begin : g_step
    if (g == 0) begin : g_none
      assign step_q_tab[g] = '0;
      assign step_r_tab[g] = '0;
    end else begin : g_div
      localparam logic [63:0] NUM = 64'h1_0000_0000;
      localparam logic [63:0] SQ  = NUM / 64'(g);
      localparam logic [63:0] SR  = NUM % 64'(g);
      assign step_q_tab[g] = SQ[ANG_W-1:0];
      assign step_r_tab[g] = SR[DEG_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Copy sequencer
  // --------------------------------------------------------------------------
  logic              cur_vld_q, cur_vld_d;
  face_t             cur_q;
  logic [COPY_W-1:0] k_q, k_d;
  logic [ANG_W-1:0]  aq_q, aq_d;
  logic [DEG_W-1:0]  ar_q, ar_d;
  logic              cur_last;
  logic [DEG_W:0]    r_sum;

  assign cur_last = (32'(k_q) + 32'd1 == 32'(deg_i));
  assign pop_o    = en && (!cur_vld_q || cur_last) && !q_stat_i.empty;
  assign r_sum    = {1'b0, ar_q} + {1'b0, step_r_tab[deg_i]};

  // Step the copy angle exactly: floor((k*2^32 + D/2) / D)
  always_comb begin
    cur_vld_d = cur_vld_q;
    k_d       = k_q;
    aq_d      = aq_q;
    ar_d      = ar_q;
    if (en && cur_vld_q) begin
      if (cur_last) begin
        cur_vld_d = 1'b0;
      end else begin
        k_d = k_q + COPY_W'(1);
        if (r_sum >= {1'b0, deg_i}) begin
          ar_d = DEG_W'(r_sum - {1'b0, deg_i});
          aq_d = aq_q + step_q_tab[deg_i] + ANG_W'(1);
        end else begin
          ar_d = r_sum[DEG_W-1:0];
          aq_d = aq_q + step_q_tab[deg_i];
        end
      end
    end
    if (pop_o) begin
      cur_vld_d = 1'b1;
      k_d       = '0;
      aq_d      = '0;
      ar_d      = deg_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q  <= k_d;
    aq_q <= aq_d;
    ar_q <= ar_d;
    if (pop_o) begin
      cur_q <= entry_i;
    end
  end

  // --------------------------------------------------------------------------
  // Issue stage: copy angle
  // --------------------------------------------------------------------------
  logic             iss_vld_q;
  logic [ANG_W-1:0] iss_ang_q;
  copy_t            iss_car_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_vld_q <= 1'b0;
    end else if (en) begin
      iss_vld_q <= cur_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      iss_ang_q            <= cur_q.phi + aq_q;
      iss_car_q.b1         <= cur_q.b1;
      iss_car_q.b2         <= cur_q.b2;
      iss_car_q.len        <= cur_q.len;
      iss_car_q.copy_index <= k_q;
      iss_car_q.last_copy  <= cur_last;
    end
  end

  // --------------------------------------------------------------------------
  // Fold (index 0) and rotation steps (index 1..NS)
  // --------------------------------------------------------------------------
  logic                 rv_q [NS+1];
  logic signed [CW-1:0] rz_q [NS+1];
  logic signed [CW-1:0] ru_q [NS+1];
  logic signed [CW-1:0] rw_q [NS+1];
  logic                 rf_q [NS+1];
  copy_t                rc_q [NS+1];

  logic                 rv_d [NS+1];
  logic signed [CW-1:0] rz_d [NS+1];
  logic signed [CW-1:0] ru_d [NS+1];
  logic signed [CW-1:0] rw_d [NS+1];
  logic                 rf_d [NS+1];
  copy_t                rc_d [NS+1];

  // Fold the angle into the right half plane, remember to flip the result
  always_comb begin
    logic signed [CW-1:0] z;
    z = CW'($signed(iss_ang_q));
    rf_d[0] = 1'b0;
    if (z > QTR) begin
      z       = z - HALF;
      rf_d[0] = 1'b1;
    end else if (z < -QTR) begin
      z       = z + HALF;
      rf_d[0] = 1'b1;
    end
    rz_d[0] = z;
    ru_d[0] = GAIN_INV;
    rw_d[0] = '0;
    rv_d[0] = iss_vld_q;
    rc_d[0] = iss_car_q;
  end

  for (genvar s = 1; s <= NS; s++) begin : g_rot
    localparam int unsigned ST = s - 1;
    localparam logic signed [CW-1:0] ATN = CW'({2'b00, TURN_ATAN[ST]});

    // Rotate by the step angle toward zero residual
    always_comb begin
      logic signed [CW-1:0] du;
      logic signed [CW-1:0] dw;
      du = ru_q[s-1] >>> ST;
      dw = rw_q[s-1] >>> ST;
      if (rz_q[s-1] >= 0) begin
        ru_d[s] = ru_q[s-1] - dw;
        rw_d[s] = rw_q[s-1] + du;
        rz_d[s] = rz_q[s-1] - ATN;
      end else begin
        ru_d[s] = ru_q[s-1] + dw;
        rw_d[s] = rw_q[s-1] - du;
        rz_d[s] = rz_q[s-1] + ATN;
      end
      rv_d[s] = rv_q[s-1];
      rf_d[s] = rf_q[s-1];
      rc_d[s] = rc_q[s-1];
    end
  end

  for (genvar s = 0; s <= NS; s++) begin : g_rreg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[s] <= 1'b0;
      end else if (en) begin
        rv_q[s] <= rv_d[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rz_q[s] <= rz_d[s];
        ru_q[s] <= ru_d[s];
        rw_q[s] <= rw_d[s];
        rf_q[s] <= rf_d[s];
        rc_q[s] <= rc_d[s];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Unfold, rebuild in 3D, scale by length, round and saturate
  // --------------------------------------------------------------------------
  logic                  n_vld_q;
  logic signed [CW-1:0]  co_q;
  logic signed [CW-1:0]  si_q;
  copy_t                 n_car_q;

  logic                  p_vld_q;
  logic signed [PW-1:0]  p1_q [3];
  logic signed [PW-1:0]  p2_q [3];
  copy_t                 p_car_q;

  logic                  t_vld_q;
  logic signed [TW-1:0]  t_q [3];
  copy_t                 t_car_q;

  logic                  m_vld_q;
  logic signed [MW-1:0]  m_q [3];
  copy_t                 m_car_q;

  logic signed [OUT_W-1:0] out_q [3];
  copy_t                   out_car_q;

  logic signed [PW:0]      t_full [3];
  logic signed [PW:0]      t_shift [3];
  logic signed [MW:0]      o_full [3];
  logic signed [MW:0]      o_shift [3];
  logic signed [OUT_W-1:0] o_sat [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      t_full[c]  = (PW+1)'(p1_q[c]) + (PW+1)'(p2_q[c]) + (PW+1)'(2**19);
      t_shift[c] = t_full[c] >>> 20;
      o_full[c]  = (MW+1)'(m_q[c]) + (MW+1)'(2**23);
      o_shift[c] = o_full[c] >>> 24;
      if (o_shift[c] > (MW+1)'(OMAX)) begin
        o_sat[c] = OMAX[OUT_W-1:0];
      end else if (o_shift[c] < -(MW+1)'(OMAX) - (MW+1)'(1)) begin
        o_sat[c] = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        o_sat[c] = o_shift[c][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q   <= 1'b0;
      p_vld_q   <= 1'b0;
      t_vld_q   <= 1'b0;
      m_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      n_vld_q   <= rv_q[NS];
      p_vld_q   <= n_vld_q;
      t_vld_q   <= p_vld_q;
      m_vld_q   <= t_vld_q;
      out_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      co_q      <= rf_q[NS] ? -ru_q[NS] : ru_q[NS];
      si_q      <= rf_q[NS] ? -rw_q[NS] : rw_q[NS];
      n_car_q   <= rc_q[NS];
      p_car_q   <= n_car_q;
      t_car_q   <= p_car_q;
      m_car_q   <= t_car_q;
      out_car_q <= m_car_q;
      for (int c = 0; c < 3; c++) begin
        p1_q[c]  <= co_q * $signed(n_car_q.b1[c]);
        p2_q[c]  <= si_q * $signed(n_car_q.b2[c]);
        t_q[c]   <= t_shift[c][TW-1:0];
        m_q[c]   <= $signed({1'b0, t_car_q.len}) * t_q[c];
        out_q[c] <= o_sat[c];
      end
    end
  end

  assign vec_o.valid      = out_vld_q;
  assign vec_o.out_x      = out_q[0];
  assign vec_o.out_y      = out_q[1];
  assign vec_o.out_z      = out_q[2];
  assign vec_o.copy_index = out_car_q.copy_index;
  assign vec_o.last_copy  = out_car_q.last_copy;

endmodule

// File: hw/rtl/rosy_field_vector_expand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rosy_field_vector_expand
// Expands one representative vector per face into its rotationally
// symmetric copies in the face's tangent plane.
// ----------------------------------------------------------------------------
// A face enters on face_i; D result vectors leave on vec_o in copy order,
// one per cycle unless vec_o stalls, where D is field_degree clamped to
// 1..MAX_DEGREE. The front takes a face every cycle unless its finished
// face meets a full queue, through a 26-stage angle and length pipeline;
// the back emits one copy per cycle unless vec_o stalls, through a 31-stage
// rotation and scaling pipeline. A four-entry queue between the two lets
// the front keep accepting while the back drains copies. Write field_degree
// only when no face is in flight.
// ----------------------------------------------------------------------------
`include "rosy_field_vector_expand_defines.svh"

module rosy_field_vector_expand import rfve_pkg::*; #(
  parameter int unsigned MAX_DEGREE  = MAX_DEGREE_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [DEG_REG_W-1:0] cfg_wdata_i,
  rfve_face_if.sink            face_i,
  rfve_vec_if.source           vec_o
);

  localparam int unsigned DEG_W = $clog2(MAX_DEGREE + 1);

  // Degree register
  logic [DEG_REG_W-1:0] field_degree_q;
  logic [DEG_W-1:0]     deg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_degree_q <= DEG_REG_W'(1);
    end else if (cfg_we_i) begin
      field_degree_q <= cfg_wdata_i;
    end
  end

  // Clamp degree to 1..MAX_DEGREE
  always_comb begin
    if (field_degree_q == '0) begin
      deg = DEG_W'(1);
    end else if (32'(field_degree_q) > MAX_DEGREE) begin
      deg = DEG_W'(MAX_DEGREE);
    end else begin
      deg = DEG_W'(field_degree_q);
    end
  end

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  face_t   push_data;
  face_t   pop_data;

  rfve_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .face_i   (face_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .entry_o  (push_data)
  );

  rfve_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .pop_i  (pop),
    .data_o (pop_data),
    .stat_o (q_stat)
  );

  rfve_back #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .deg_i    (deg),
    .q_stat_i (q_stat),
    .entry_i  (pop_data),
    .pop_o    (pop),
    .vec_o    (vec_o)
  );

  // Copies of one face leave back to back in rising order
  `RFVE_ASSERT_NEXT(a_copy_follow, vec_o.valid && vec_o.ready && !vec_o.last_copy, vec_o.valid && (vec_o.copy_index == $past(vec_o.copy_index) + COPY_W'(1)), "copy sequence broken")
  // A new face always starts at copy zero
  `RFVE_ASSERT_NEXT(a_face_start, vec_o.valid && vec_o.ready && vec_o.last_copy, !vec_o.valid || (vec_o.copy_index == '0), "face did not start at copy zero")

endmodule

// File: dv/rfve_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfve_checker
// Watches the face and vector channels of the field vector expansion block.
// It predicts every rotated copy of each accepted face and compares each
// accepted vector, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module rfve_checker import rfve_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [DEG_REG_W-1:0] cfg_wdata_i,
  rfve_face_if                 face,
  rfve_vec_if                  vec,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic [COPY_W-1:0]       idx;
    logic                    last;
  } copy_vec_t;

  copy_vec_t           copies_due[$];
  logic [DEG_REG_W-1:0] degree_reg;

  // Round by adding half, then floor shift
  function automatic longint round_drop(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, probe;
    res   = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v   = v - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC: in-plane angle of (pa, pb), full turn = 2^32
  function automatic logic [ANG_W-1:0] plane_angle(longint pa, longint pb);
    logic [ANG_W-1:0] acc;
    longint da, db;
    acc = '0;
    if (pa == 0 && pb == 0) return '0;
    if (pa < 0) begin
      pa  = -pa;
      pb  = -pb;
      acc = 32'h8000_0000;
    end
    for (int st = 0; st < CORDIC_STEPS; st++) begin
      da = pa >>> st;
      db = pb >>> st;
      if (pb > 0) begin
        pa  = pa + db;
        pb  = pb - da;
        acc = acc + TURN_ATAN[st];
      end else begin
        pa  = pa - db;
        pb  = pb + da;
        acc = acc - TURN_ATAN[st];
      end
    end
    return acc;
  endfunction

  // Rotation CORDIC: cos and sin of an angle in Q.30
  function automatic void cos_sin(input logic [ANG_W-1:0] a, output longint co,
                                  output longint si);
    longint z, u, v, du, dv;
    bit     flip;
    z    = longint'({32'd0, a});
    u    = 64'sd652032874;
    v    = 0;
    flip = 1'b0;
    if (z >= (64'sd1 <<< 31)) z = z - (64'sd1 <<< 32);
    if (z > (64'sd1 <<< 30)) begin
      z    = z - (64'sd1 <<< 31);
      flip = 1'b1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z    = z + (64'sd1 <<< 31);
      flip = 1'b1;
    end
    for (int st = 0; st < CORDIC_STEPS; st++) begin
      du = u >>> st;
      dv = v >>> st;
      if (z >= 0) begin
        u = u - dv;
        v = v + du;
        z = z - longint'({32'd0, TURN_ATAN[st]});
      end else begin
        u = u + dv;
        v = v - du;
        z = z + longint'({32'd0, TURN_ATAN[st]});
      end
    end
    co = flip ? -u : u;
    si = flip ? -v : v;
  endfunction

  function automatic logic signed [OUT_W-1:0] clip_out(longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[OUT_W-1:0];
  endfunction

  // Queue up the expected copies of one face
  task automatic expand_face();
    longint r[3], e1[3], e2[3];
    longint pa, pb, len, co, si, t[3];
    longint unsigned sq, deg, step_ang;
    logic [ANG_W-1:0] phi, a;
    copy_vec_t cv;
    r[0]  = longint'(face.r_x);   r[1]  = longint'(face.r_y);   r[2]  = longint'(face.r_z);
    e1[0] = longint'(face.b1_x);  e1[1] = longint'(face.b1_y);  e1[2] = longint'(face.b1_z);
    e2[0] = longint'(face.b2_x);  e2[1] = longint'(face.b2_y);  e2[2] = longint'(face.b2_z);
    pa = 0;
    pb = 0;
    sq = 0;
    for (int c = 0; c < 3; c++) begin
      pa = pa + r[c] * e1[c];
      pb = pb + r[c] * e2[c];
      sq = sq + longint'(r[c] * r[c]);
    end
    len = longint'(int_sqrt(sq));
    phi = plane_angle(pa, pb);
    deg = degree_reg;
    if (deg < 1) deg = 1;
    if (deg > MAX_DEGREE_DEF) deg = MAX_DEGREE_DEF;
    for (longint unsigned k = 0; k < deg; k++) begin
      step_ang = ((k << 32) + deg / 2) / deg;
      a = phi + step_ang[31:0];
      cos_sin(a, co, si);
      for (int c = 0; c < 3; c++) t[c] = round_drop(co * e1[c] + si * e2[c], 20);
      cv.x    = clip_out(round_drop(len * t[0], 24));
      cv.y    = clip_out(round_drop(len * t[1], 24));
      cv.z    = clip_out(round_drop(len * t[2], 24));
      cv.idx  = k[COPY_W-1:0];
      cv.last = (k + 1 == deg);
      copies_due.push_back(cv);
    end
  endtask

  // Track the degree register, predict on face items, compare vector items
  always @(posedge clk_i or negedge rst_ni) begin
    copy_vec_t want;
    if (!rst_ni) begin
      degree_reg <= 4'd1;
    end else begin
      if (cfg_we_i) degree_reg <= cfg_wdata_i;
      if (face.valid && face.ready) expand_face();
      if (vec.valid && vec.ready) begin
        if (copies_due.size() == 0) begin
          $display("%0t: unexpected vector x=%0d y=%0d z=%0d idx=%0d last=%0d", $time,
                   vec.out_x, vec.out_y, vec.out_z, vec.copy_index, vec.last_copy);
          fail_count_o++;
        end else begin
          want = copies_due.pop_front();
          if (vec.out_x !== want.x || vec.out_y !== want.y || vec.out_z !== want.z ||
              vec.copy_index !== want.idx || vec.last_copy !== want.last) begin
            $display("%0t: expected x=%0d y=%0d z=%0d idx=%0d last=%0d", $time,
                     want.x, want.y, want.z, want.idx, want.last);
            $display("%0t: actual   x=%0d y=%0d z=%0d idx=%0d last=%0d", $time,
                     vec.out_x, vec.out_y, vec.out_z, vec.copy_index, vec.last_copy);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = copies_due.size();
  end

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives faces into the field vector expansion block under several degree
// settings, with random gaps and output stalls, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import rfve_pkg::*;

  localparam int IDLE_LIMIT  = 5000;
  localparam int SETTLE_CYC  = 100;

  typedef struct {
    logic signed [R_W-1:0] r[3];
    logic signed [B_W-1:0] u[3];
    logic signed [B_W-1:0] w[3];
  } face_item_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we;
  logic [DEG_REG_W-1:0] cfg_wdata;
  int                   fail_count, pending;
  int                   idle_cycles;
  bit                   calm;

  rfve_face_if face_ch ();
  rfve_vec_if  vec_ch ();

  rosy_field_vector_expand dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .face_i     (face_ch),
    .vec_o      (vec_ch)
  );

  rfve_checker checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .face        (face_ch),
    .vec         (vec_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #1 clk_i = ~clk_i;

  // Stall the vector sink in random bursts, with calm stretches
  int stall_left = 0;
  int run_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      vec_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      vec_ch.ready <= 1'b1;
      if (run_left > 0) begin
        run_left--;
      end else if (!calm) begin
        case ($urandom_range(0, 9))
          0, 1, 2: stall_left = $urandom_range(1, 8);
          3:       run_left = $urandom_range(20, 80);
          default: ;
        endcase
      end
    end
  end

  // Stop when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((face_ch.valid && face_ch.ready) || (vec_ch.valid && vec_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Offer one face and hold it until taken; called at a rising edge
  task automatic send_face(face_item_t f);
    if (!calm && $urandom_range(0, 3) == 0) begin
      face_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    face_ch.valid <= 1'b1;
    face_ch.r_x  <= f.r[0];  face_ch.r_y  <= f.r[1];  face_ch.r_z  <= f.r[2];
    face_ch.b1_x <= f.u[0];  face_ch.b1_y <= f.u[1];  face_ch.b1_z <= f.u[2];
    face_ch.b2_x <= f.w[0];  face_ch.b2_y <= f.w[1];  face_ch.b2_z <= f.w[2];
    do @(posedge clk_i); while (!face_ch.ready);
  endtask

  // Drain everything, then let in-flight work settle
  task automatic drain();
    face_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_degree(logic [DEG_REG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic face_item_t make_face(logic signed [R_W-1:0] rx, ry, rz,
                                           logic signed [B_W-1:0] ux, uy, uz,
                                           logic signed [B_W-1:0] wx, wy, wz);
    face_item_t f;
    f.r = '{rx, ry, rz};
    f.u = '{ux, uy, uz};
    f.w = '{wx, wy, wz};
    return f;
  endfunction

  // Mostly unit orthogonal axis bases with random vectors, some raw noise
  function automatic face_item_t rand_face();
    face_item_t f;
    int a1, a2;
    int sel;
    sel = $urandom_range(0, 9);
    for (int c = 0; c < 3; c++) begin
      f.r[c] = R_W'($signed($urandom) >>> $urandom_range(8, 31));
      f.u[c] = B_W'($urandom);
      f.w[c] = B_W'($urandom);
    end
    if (sel == 0) begin
      for (int c = 0; c < 3; c++) f.r[c] = R_W'($urandom);
    end else if (sel >= 2) begin
      a1 = $urandom_range(0, 2);
      a2 = (a1 + $urandom_range(1, 2)) % 3;
      for (int c = 0; c < 3; c++) begin
        f.u[c] = B_W'($signed($urandom_range(0, 15)) - 8);
        f.w[c] = B_W'($signed($urandom_range(0, 15)) - 8);
      end
      f.u[a1] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      f.w[a2] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    end
    return f;
  endfunction

  initial begin
    int degrees[] = '{1, 0, 9, 15, 3, 7, 2, 5, 8, 4, 6, 12};
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    calm          = 1'b0;
    idle_cycles   = 0;
    vec_ch.ready  = 1'b0;
    face_ch.valid = 1'b0;
    face_ch.r_x = '0;  face_ch.r_y = '0;  face_ch.r_z = '0;
    face_ch.b1_x = '0; face_ch.b1_y = '0; face_ch.b1_z = '0;
    face_ch.b2_x = '0; face_ch.b2_y = '0; face_ch.b2_z = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed faces at the highest degree
    write_degree(4'd9);
    send_face(make_face(0, 0, 0, 16384, 0, 0, 0, 16384, 0));
    send_face(make_face(65536, 0, 0, 16384, 0, 0, 0, 16384, 0));
    send_face(make_face(-65536, 0, 0, 16384, 0, 0, 0, 16384, 0));
    send_face(make_face(0, 65536, 0, 16384, 0, 0, 0, 16384, 0));
    send_face(make_face(0, -65536, 0, 16384, 0, 0, 0, 16384, 0));
    send_face(make_face(0, 0, 65536, 16384, 0, 0, 0, 16384, 0));
    send_face(make_face(8388607, 8388607, 8388607, 16384, 0, 0, 0, 16384, 0));
    send_face(make_face(-8388608, -8388608, -8388608, 0, 16384, 0, 0, 0, 16384));
    send_face(make_face(8388607, -8388608, 8388607,
                        -32768, -32768, -32768, 32767, 32767, 32767));
    send_face(make_face(-8388608, 8388607, -8388608,
                        32767, -32768, 32767, -32768, 32767, -32768));
    send_face(make_face(1, 0, 0, 16384, 0, 0, 0, 16384, 0));
    send_face(make_face(-1, -1, -1, 16384, 0, 0, 0, 16384, 0));
    send_face(make_face(100000, 200000, 0, 0, 0, 0, 0, 0, 0));
    send_face(make_face(300000, -300000, 70000, 11585, 11585, 0, -11585, 11585, 0));
    send_face(make_face(-300000, 1, 0, 16384, 0, 0, 0, 16384, 0));
    send_face(make_face(5000000, 5000000, 0, 20000, 20000, 0, -20000, 20000, 0));
    drain();

    // Random faces over a sweep of degrees
    foreach (degrees[i]) begin
      if (i > 0) write_degree(DEG_REG_W'(degrees[i]));
      if (i == degrees.size() - 1) calm = 1'b1;
      repeat (30) send_face(rand_face());
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
